// ----- rtl/smpq_pkg.sv -----
// package with payload types, command codes and defaults for the sorted max priority queue
`timescale 1ns / 1ps
package smpq_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int VALUE_W          = 31;
  localparam int RESULT_W         = 32;
  localparam int COUNT_FIELD_W    = 5;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic signed [RESULT_W-1:0] EMPTY_CODE = -32'sd1;

  typedef struct packed {
    logic               command;
    logic [VALUE_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] popped_value;
    logic                       now_empty;
    logic [COUNT_FIELD_W-1:0]   entry_count;
    logic                       dropped;
  } out_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [VALUE_W-1:0] value;
  } cell_op_t;

  typedef struct packed {
    logic               ge;
    logic [VALUE_W-1:0] value;
  } cell_link_t;

endpackage

// ----- rtl/sorted_max_priority_queue.sv -----
// top level of the sorted max priority queue built as a chain of compare cells
// the done strobe is registered from the start transfer and rises in the cycle after it
// throughput: one command per cycle, busy stays low, every cell compares in parallel
// the receiver cannot stall, each result is shown for exactly one cycle
// reset clears the entry count and the done strobe; cell contents are left as is
`timescale 1ns / 1ps
module sorted_max_priority_queue #(
  parameter int CAPACITY = smpq_pkg::CAPACITY_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  smpq_pkg::in_t  item,
  output logic           done,
  output smpq_pkg::out_t result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 accept;
  logic                 full;
  logic                 empty;
  smpq_pkg::cell_op_t   op;
  smpq_pkg::cell_link_t link [CAPACITY];
  smpq_pkg::cell_link_t up   [CAPACITY];
  smpq_pkg::cell_link_t down [CAPACITY];
  smpq_pkg::out_t       result_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = count == CNT_W'(CAPACITY);
  assign empty  = count == '0;

  assign op.push  = accept && (item.command == smpq_pkg::CMD_PUSH) && !full;
  assign op.pop   = accept && (item.command == smpq_pkg::CMD_POP) && !empty;
  assign op.value = item.push_value;

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_top
        assign up[i] = '{ge: 1'b1, value: '0};
      end else begin : g_mid
        assign up[i] = link[i-1];
      end
      if (i == CAPACITY - 1) begin : g_end
        assign down[i] = link[i];
      end else begin : g_inner
        assign down[i] = link[i+1];
      end
      smpq_cell #(
        .CNT_W (CNT_W),
        .INDEX (i)
      ) u_cell (
        .clk       (clk),
        .op        (op),
        .count     (count),
        .from_up   (up[i]),
        .from_down (down[i]),
        .link      (link[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (op.push) begin
      count_next = count + CNT_W'(1);
    end else if (op.pop) begin
      count_next = count - CNT_W'(1);
    end
    result_next.popped_value = op.pop ? {1'b0, link[0].value} : smpq_pkg::EMPTY_CODE;
    result_next.now_empty    = count_next == '0;
    result_next.entry_count  = smpq_pkg::COUNT_FIELD_W'(count_next);
    result_next.dropped      = accept && (item.command == smpq_pkg::CMD_PUSH) && full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

// ----- rtl/smpq_cell.sv -----
// one storage cell of the sorted chain, largest entry at index zero
`timescale 1ns / 1ps
module smpq_cell #(
  parameter int CNT_W = 5,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  smpq_pkg::cell_op_t   op,
  input  logic [CNT_W-1:0]     count,
  input  smpq_pkg::cell_link_t from_up,
  input  smpq_pkg::cell_link_t from_down,
  output smpq_pkg::cell_link_t link
);

  logic [smpq_pkg::VALUE_W-1:0] value;
  logic                         live;

  assign live       = count > CNT_W'(INDEX);
  assign link.ge    = live && (value >= op.value);
  assign link.value = value;

  always_ff @(posedge clk) begin
    if (op.push) begin
      if (!link.ge) begin
        value <= from_up.ge ? op.value : from_up.value;
      end
    end else if (op.pop) begin
      value <= from_down.value;
    end
  end

endmodule

// ----- rtl/smpq_checker.sv -----
// port level checker for the sorted max priority queue and its bind
`timescale 1ns / 1ps
module smpq_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input smpq_pkg::in_t  item,
  input logic           done,
  input smpq_pkg::out_t result
);

  // each start transfer gives a strobe in the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("missing done after start transfer");

  // no strobe without a transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("done without start transfer");

  // a dropped push returns the empty code
  a_drop_code: assert property (@(posedge clk) disable iff (rst)
    (done && result.dropped) |-> (result.popped_value == smpq_pkg::EMPTY_CODE))
    else $error("dropped push returned a value");

  // a returned value comes only from a pop and is never negative
  a_value_from_pop: assert property (@(posedge clk) disable iff (rst)
    (done && (result.popped_value != smpq_pkg::EMPTY_CODE)) |->
      (($past(item.command) == smpq_pkg::CMD_POP) && !result.popped_value[31]
       && !result.dropped))
    else $error("value returned without a pop");

endmodule

bind sorted_max_priority_queue smpq_checker u_smpq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

// ----- tb/sorted_max_priority_queue_test.sv -----
// self-checking testbench for the sorted max priority queue against a behavioral copy of its store
`timescale 1ns / 1ps
module sorted_max_priority_queue_test;

  localparam int CAP   = smpq_pkg::CAPACITY_DEFAULT;
  localparam int VAL_W = smpq_pkg::VALUE_W;
  localparam int CNT_FW = smpq_pkg::COUNT_FIELD_W;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  smpq_pkg::in_t  item = '0;
  logic           busy;
  logic           done;
  smpq_pkg::out_t result;

  logic [VAL_W-1:0] model_entries [CAP];
  int unsigned      model_count = 0;
  smpq_pkg::out_t   pending_results [$];
  int               errors = 0;
  bit               calm = 1'b0;

  sorted_max_priority_queue #(.CAPACITY(CAP)) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic smpq_pkg::out_t next_queue_result(smpq_pkg::in_t it);
    smpq_pkg::out_t r;
    int unsigned    pos;
    r.popped_value = smpq_pkg::EMPTY_CODE;
    r.dropped      = 1'b0;
    if (it.command == smpq_pkg::CMD_PUSH) begin
      if (model_count >= CAP) begin
        r.dropped = 1'b1;
      end else begin
        pos = model_count;
        while (pos > 0 && model_entries[pos-1] > it.push_value) begin
          model_entries[pos] = model_entries[pos-1];
          pos--;
        end
        model_entries[pos] = it.push_value;
        model_count++;
      end
    end else if (model_count > 0) begin
      model_count--;
      r.popped_value = {1'b0, model_entries[model_count]};
    end
    r.now_empty   = (model_count == 0);
    r.entry_count = model_count[CNT_FW-1:0];
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 3))
      0: return raw[VAL_W-1:0];
      1: return VAL_W'($urandom_range(0, 7));
      2: return {VAL_W{1'b1}} - VAL_W'($urandom_range(0, 3));
      default: return VAL_W'(raw >> $urandom_range(1, 31));
    endcase
  endfunction

  task automatic report(string field, longint exp_v, longint act_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
  endtask

  // result checker, one transfer per done strobe
  always @(posedge clk) begin
    smpq_pkg::out_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, result);
      end else begin
        exp_r = pending_results.pop_front();
        if (result.popped_value !== exp_r.popped_value)
          report("popped_value", exp_r.popped_value, result.popped_value);
        if (result.now_empty !== exp_r.now_empty)
          report("now_empty", exp_r.now_empty, result.now_empty);
        if (result.entry_count !== exp_r.entry_count)
          report("entry_count", exp_r.entry_count, result.entry_count);
        if (result.dropped !== exp_r.dropped)
          report("dropped", exp_r.dropped, result.dropped);
      end
    end
  end

  task automatic send_item(logic cmd, logic [VAL_W-1:0] val);
    smpq_pkg::in_t it;
    it.command    = cmd;
    it.push_value = val;
    while (!calm && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(next_queue_result(it));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic test_pop_empty();
    send_item(smpq_pkg::CMD_POP, '0);
    send_item(smpq_pkg::CMD_POP, {VAL_W{1'b1}});
    send_item(smpq_pkg::CMD_PUSH, VAL_W'(5));
    send_item(smpq_pkg::CMD_POP, '0);
    send_item(smpq_pkg::CMD_POP, '0);
  endtask

  task automatic test_fill_overflow();
    send_item(smpq_pkg::CMD_PUSH, {VAL_W{1'b1}});
    send_item(smpq_pkg::CMD_PUSH, '0);
    send_item(smpq_pkg::CMD_PUSH, {VAL_W{1'b1}});
    for (int i = 0; i < CAP - 3; i++)
      send_item(smpq_pkg::CMD_PUSH, VAL_W'(i * 32'h0A3D_70A3));
    send_item(smpq_pkg::CMD_PUSH, VAL_W'(32'h1234_5678));
    send_item(smpq_pkg::CMD_POP, '0);
    send_item(smpq_pkg::CMD_PUSH, '0);
    send_item(smpq_pkg::CMD_PUSH, {VAL_W{1'b1}});
  endtask

  task automatic test_random_mix(int count, int push_pct);
    for (int i = 0; i < count; i++)
      send_item(($urandom_range(0, 99) < push_pct) ? smpq_pkg::CMD_PUSH : smpq_pkg::CMD_POP,
                random_value());
  endtask

  task automatic test_back_to_back(int count);
    calm = 1'b1;
    test_random_mix(count, 55);
    calm = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_pop_empty();
    test_fill_overflow();
    wait_drained();
    test_random_mix(140, 50);
    test_back_to_back(80);
    wait_drained();
    test_random_mix(90, 75);
    test_random_mix(90, 30);
    wait_drained();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/sorted_max_priority_queue.sv
rtl/smpq_checker.sv
tb/sorted_max_priority_queue_test.sv
